// ===== design/lab_pkg.sv =====
// Shared types, character codes and sizes for the line assembler.
package lab_pkg;

	localparam int LINE_CAPACITY = 63;
	localparam int CFG_W = 6;
	localparam int BYTE_W = 8;
	localparam int ADDR_W = (LINE_CAPACITY > 1) ? $clog2(LINE_CAPACITY) : 1;
	localparam int CNT_W = $clog2(LINE_CAPACITY + 1);
	localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CFG_W-1:0] cfg_t;
	typedef logic [CMP_W-1:0] cmp_t;

	localparam byte_t CH_BREAK = 8'h03;
	localparam byte_t CH_CR = 8'h0D;
	localparam byte_t CH_LF = 8'h0A;
	localparam byte_t CH_NUL = 8'h00;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_OVERFLOW = 1'b1;

	localparam cfg_t MAX_LEN_RESET = 6'd63;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REPLAY,
		ST_TERM
	} lab_state_t;

endpackage

// ===== design/lab_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lab_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                          wr_data,
	input  logic                                      rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                          rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/line_assembler_with_break_unit.sv =====
// Line assembler: buffers bytes in a RAM and replays a line on newline or NUL; ctrl-C drops it.
// Ordinary bytes and carriage returns do not leave idle; input is accepted every cycle
// while idle and while the output register is free or being drained.
// A line end with held bytes blocks input while they replay: each byte goes through the
// line RAM read register into the output register, one byte per cycle while the output is
// not stalled, then the terminator. Ctrl-C blocks input while the terminator after 0x03 is sent.
// Reset clears the fill count and the output valid and sets the length limit to 63;
// the line RAM is not cleared, since only written entries are ever replayed.
module line_assembler_with_break_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [7:0] in_byte
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [7:0] out_byte
	output logic       m_axis_tuser,  // [0] out_kind
	output logic       m_axis_tlast,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] cfg_data       // max_line_length
);

	lab_pkg::lab_state_t state_q, state_d;
	lab_pkg::cnt_t fill_q, idx_q, len_q;
	lab_pkg::cfg_t max_len_q;

	logic out_valid_q;
	lab_pkg::byte_t out_byte_q;
	logic out_kind_q, out_last_q;

	logic slot_free, acc, is_break, is_cr, is_eol, room;
	logic ld, ld_kind, ld_last;
	lab_pkg::byte_t ld_byte;
	logic wr_en, rd_en;
	lab_pkg::addr_t rd_addr;
	lab_pkg::byte_t rd_data;
	logic fill_clr, fill_inc, idx_start, idx_inc;

	assign slot_free = !out_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == lab_pkg::ST_IDLE) && slot_free;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign cfg_ready = 1'b1;

	assign is_break = (s_axis_tdata == lab_pkg::CH_BREAK);
	assign is_cr = (s_axis_tdata == lab_pkg::CH_CR);
	assign is_eol = (s_axis_tdata == lab_pkg::CH_LF) || (s_axis_tdata == lab_pkg::CH_NUL);
	assign room = (lab_pkg::cmp_t'(fill_q) < lab_pkg::cmp_t'(max_len_q))
		&& (fill_q < lab_pkg::cnt_t'(lab_pkg::LINE_CAPACITY));

	// Writes happen only in idle, and a line-end read never comes in the same cycle as a write,
	// so the read always sees the last written byte.
	lab_ram #(
		.WIDTH(lab_pkg::BYTE_W),
		.DEPTH(lab_pkg::LINE_CAPACITY)
	) u_line_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(fill_q[lab_pkg::ADDR_W-1:0]),
		.wr_data(s_axis_tdata),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lab_pkg::ST_IDLE: begin
				if (acc && is_break) begin
					state_d = lab_pkg::ST_TERM;
				end else if (acc && is_eol && (fill_q != '0)) begin
					state_d = lab_pkg::ST_REPLAY;
				end
			end
			lab_pkg::ST_REPLAY: begin
				if (slot_free && (idx_q == len_q)) begin
					state_d = lab_pkg::ST_TERM;
				end
			end
			lab_pkg::ST_TERM: begin
				if (slot_free) begin
					state_d = lab_pkg::ST_IDLE;
				end
			end
			default: state_d = lab_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ld = 1'b0;
		ld_byte = '0;
		ld_kind = lab_pkg::KIND_DATA;
		ld_last = 1'b0;
		wr_en = 1'b0;
		rd_en = 1'b0;
		rd_addr = '0;
		fill_clr = 1'b0;
		fill_inc = 1'b0;
		idx_start = 1'b0;
		idx_inc = 1'b0;
		unique case (state_q)
			lab_pkg::ST_IDLE: begin
				if (acc) begin
					priority if (is_break) begin
						ld = 1'b1;
						ld_byte = lab_pkg::CH_BREAK;
						fill_clr = 1'b1;
					end else if (is_cr) begin
						// drop
					end else if (is_eol) begin
						fill_clr = 1'b1;
						if (fill_q == '0) begin
							ld = 1'b1;
							ld_last = 1'b1;
						end else begin
							rd_en = 1'b1;
							idx_start = 1'b1;
						end
					end else if (room) begin
						wr_en = 1'b1;
						fill_inc = 1'b1;
					end else begin
						ld = 1'b1;
						ld_kind = lab_pkg::KIND_OVERFLOW;
						ld_last = 1'b1;
					end
				end
			end
			lab_pkg::ST_REPLAY: begin
				// read data holds until the next read, so a stall just waits
				if (slot_free) begin
					ld = 1'b1;
					ld_byte = rd_data;
					if (idx_q != len_q) begin
						rd_en = 1'b1;
						rd_addr = idx_q[lab_pkg::ADDR_W-1:0];
						idx_inc = 1'b1;
					end
				end
			end
			lab_pkg::ST_TERM: begin
				if (slot_free) begin
					ld = 1'b1;
					ld_last = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lab_pkg::ST_IDLE;
			fill_q <= '0;
			max_len_q <= lab_pkg::MAX_LEN_RESET;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fill_clr) begin
				fill_q <= '0;
			end else if (fill_inc) begin
				fill_q <= fill_q + lab_pkg::cnt_t'(1);
			end
			if (cfg_valid && cfg_ready) begin
				max_len_q <= cfg_data;
			end
			if (ld) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			out_byte_q <= ld_byte;
			out_kind_q <= ld_kind;
			out_last_q <= ld_last;
		end
		if (idx_start) begin
			idx_q <= lab_pkg::cnt_t'(1);
			len_q <= fill_q;
		end else if (idx_inc) begin
			idx_q <= idx_q + lab_pkg::cnt_t'(1);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = out_byte_q;
	assign m_axis_tuser = out_kind_q;
	assign m_axis_tlast = out_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= lab_pkg::cnt_t'(lab_pkg::LINE_CAPACITY))
		else $error("fill count above line capacity");

	a_busy_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != lab_pkg::ST_IDLE) |-> (fill_q == '0))
		else $error("fill count not cleared during replay");

	a_eol_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_eol && (fill_q != '0)) |=> (state_q == lab_pkg::ST_REPLAY))
		else $error("line end with held bytes did not start replay");

	a_overflow_out: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && !is_break && !is_cr && !is_eol && !room)
		|=> (m_axis_tvalid && (m_axis_tuser == lab_pkg::KIND_OVERFLOW) && m_axis_tlast))
		else $error("overflow result missing");

	a_replay_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == lab_pkg::ST_REPLAY) |-> (idx_q <= len_q))
		else $error("replay index past line length");

endmodule

// ===== tb/sv/tb_line_assembler_with_break_unit.sv =====
// Self-checking testbench for the line assembler with ctrl-C break and overflow reporting.
`timescale 1ns / 1ps

module tb_line_assembler_with_break_unit;
	import lab_pkg::*;

	localparam int unsigned SETTLE_CYCLES = 4;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned QUIET_LIMIT = 2000;
	localparam int unsigned MAX_PRINTED = 40;
	localparam int unsigned RANDOM_BYTES = 128;

	typedef struct packed {
		byte_t data;
		logic  kind;
		logic  last;
	} line_char_t;

	logic       clk;
	logic       arst_n;
	logic       s_axis_tvalid;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata;   // [7:0] in_byte
	logic       m_axis_tvalid;
	logic       m_axis_tready;
	logic [7:0] m_axis_tdata;   // [7:0] out_byte
	logic       m_axis_tuser;   // [0] out_kind
	logic       m_axis_tlast;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [5:0] cfg_data;       // max_line_length

	// line model state
	byte_t       held_line [LINE_CAPACITY];
	int unsigned held_len;
	cfg_t        max_len;
	line_char_t  due_out [$];

	int unsigned src_idle_pct;
	int unsigned sink_stall_pct;
	int unsigned quiet_cycles;
	int unsigned err_count;
	int unsigned bytes_sent;
	int unsigned outs_checked;
	int unsigned lines_ended;
	int unsigned overflows_seen;
	int unsigned cfg_writes;

	line_assembler_with_break_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	function automatic void expect_char(input byte_t data, input logic kind, input logic last);
		due_out.push_back('{data: data, kind: kind, last: last});
	endfunction

	// Advance the line model by one accepted byte and queue what it emits.
	function automatic void assemble_byte(input byte_t b);
		int unsigned limit;
		limit = (max_len > LINE_CAPACITY) ? LINE_CAPACITY : max_len;
		case (b)
			CH_BREAK: begin
				expect_char(CH_BREAK, KIND_DATA, 1'b0);
				expect_char(CH_NUL, KIND_DATA, 1'b1);
				held_len = 0;
			end
			CH_CR: begin
			end
			CH_LF, CH_NUL: begin
				for (int unsigned i = 0; i < held_len; i++)
					expect_char(held_line[i], KIND_DATA, 1'b0);
				expect_char(CH_NUL, KIND_DATA, 1'b1);
				held_len = 0;
			end
			default: begin
				if (held_len < limit) begin
					held_line[held_len] = b;
					held_len++;
				end else begin
					expect_char(8'h00, KIND_OVERFLOW, 1'b1);
				end
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_PRINTED)
			$display("[%0t] MISMATCH: %s", $realtime, msg);
	endtask

	// Present one byte after an optional random gap and wait for the request to be taken.
	task automatic send_byte(input byte_t b);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= byte_t'($urandom_range(0, 255));
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		do @(posedge clk); while (!s_axis_tready);
		assemble_byte(b);
		bytes_sent++;
	endtask

	// Change the limit only once every queued output has drained.
	task automatic write_max_len(input cfg_t val);
		s_axis_tvalid <= 1'b0;
		while (due_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_len = val;
		cfg_writes++;
	endtask

	task automatic test_empty_lines();
		send_byte(CH_LF);
		send_byte(CH_NUL);
	endtask

	task automatic test_line_replay();
		send_byte(8'hFF);
		send_byte(8'h01);
		send_byte(CH_CR);
		send_byte(8'h80);
		send_byte(8'h7F);
		send_byte(CH_LF);
		send_byte(8'h55);
		send_byte(CH_NUL);
	endtask

	task automatic test_break();
		send_byte(8'h41);
		send_byte(8'h42);
		send_byte(CH_BREAK);
		send_byte(CH_BREAK);
	endtask

	task automatic test_overflow();
		write_max_len(6'd2);
		send_byte(8'h10);
		send_byte(8'h20);
		send_byte(8'h30);
		send_byte(CH_LF);
	endtask

	// Held bytes survive a limit written below the fill level.
	task automatic test_limit_lowered();
		write_max_len(6'd63);
		send_byte(8'h61);
		send_byte(8'h62);
		send_byte(8'h63);
		write_max_len(6'd1);
		send_byte(8'h64);
		send_byte(CH_LF);
	endtask

	task automatic test_zero_limit();
		write_max_len(6'd0);
		send_byte(8'h31);
		send_byte(CH_CR);
		send_byte(CH_LF);
	endtask

	// Mostly well-formed lines with random content, some noise and run-on lines.
	task automatic test_random_traffic(input int unsigned n_bytes);
		int unsigned start;
		int unsigned r;
		int unsigned line_len;
		int unsigned n_lines;
		cfg_t lim;
		byte_t b;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes) begin
			r = $urandom_range(0, 99);
			if (r < 15)
				lim = 6'd0;
			else if (r < 40)
				lim = 6'd63;
			else if (r < 75)
				lim = cfg_t'($urandom_range(1, 8));
			else
				lim = cfg_t'($urandom_range(0, 63));
			write_max_len(lim);
			n_lines = $urandom_range(2, 6);
			for (int unsigned n = 0; n < n_lines && bytes_sent - start < n_bytes; n++) begin
				if ($urandom_range(0, 99) < 75)
					line_len = $urandom_range(0, 6);
				else
					line_len = lim + $urandom_range(0, 3);  // reach or pass the limit
				for (int unsigned k = 0; k < line_len; k++) begin
					r = $urandom_range(0, 99);
					if (r < 8) begin
						send_byte(CH_CR);
					end else begin
						b = byte_t'($urandom_range(0, 255));
						// keep most content bytes ordinary; the rest is raw noise
						if (r < 93 && (b == CH_BREAK || b == CH_CR || b == CH_LF || b == CH_NUL))
							b = b ^ 8'h40;
						send_byte(b);
					end
				end
				r = $urandom_range(0, 99);
				if (r < 45)
					send_byte(CH_LF);
				else if (r < 70)
					send_byte(CH_NUL);
				else if (r < 90)
					send_byte(CH_BREAK);
			end
		end
	endtask

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	always @(posedge clk) begin : check_out
		line_char_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_out.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h kind %0b last %0b",
					m_axis_tdata, m_axis_tuser, m_axis_tlast));
			end else begin
				want = due_out.pop_front();
				if (m_axis_tdata !== want.data || m_axis_tuser !== want.kind ||
						m_axis_tlast !== want.last)
					report_mismatch($sformatf(
						"output %0d: got byte %02h kind %0b last %0b, want %02h %0b %0b",
						outs_checked, m_axis_tdata, m_axis_tuser, m_axis_tlast,
						want.data, want.kind, want.last));
				if (want.kind == KIND_OVERFLOW)
					overflows_seen++;
				else if (want.last)
					lines_ended++;
			end
			outs_checked++;
		end
	end

	// End the run when no channel moves a request for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: no transfer for %0d cycles, %0d outputs pending",
				quiet_cycles, due_out.size());
			$display("tb_line_assembler_with_break_unit failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 6'd0;
		held_len = 0;
		max_len = MAX_LEN_RESET;
		quiet_cycles = 0;
		err_count = 0;
		bytes_sent = 0;
		outs_checked = 0;
		lines_ended = 0;
		overflows_seen = 0;
		cfg_writes = 0;
		src_idle_pct = 35;
		sink_stall_pct = 69;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_lines();
		test_line_replay();
		test_break();
		test_overflow();
		test_limit_lowered();
		test_zero_limit();

		test_random_traffic(RANDOM_BYTES);
		src_idle_pct = 69;
		sink_stall_pct = 35;
		test_random_traffic(RANDOM_BYTES);
		src_idle_pct = 0;
		sink_stall_pct = 0;
		test_random_traffic(RANDOM_BYTES);

		s_axis_tvalid <= 1'b0;
		while (due_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d input bytes and %0d limit writes, under three idle/stall mixes",
			bytes_sent, cfg_writes);
		$display("checked %0d output bytes: %0d line ends or breaks, %0d overflow reports",
			outs_checked, lines_ended, overflows_seen);
		if (err_count == 0)
			$display("tb_line_assembler_with_break_unit passed");
		else
			$display("tb_line_assembler_with_break_unit failed");
		$finish;
	end

endmodule
